// ===== rtl/bbep_pkg.sv =====
// Package of the binary blob extreme point finder.
// Holds field widths, pixel classes, register indexes, state and command types.
// No dependencies; every other file of the block uses it.
package bbep_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 512;

	localparam int PIX_W   = 8;
	localparam int X_W     = 10;
	localparam int Y_W     = 9;
	localparam int CFG_W   = 11;
	localparam int CFG_H_W = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
	localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

	localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_H_W-1:0] FRAME_HEIGHT_RST = 10'd480;

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_MID  = 2'd1,
		CLS_FULL = 2'd2
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_TOP    = 2'd0,
		DIR_LEFT   = 2'd1,
		DIR_BOTTOM = 2'd2,
		DIR_RIGHT  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_LOAD = 3'd0,
		ST_DIM  = 3'd1,
		ST_MUL  = 3'd2,
		ST_SCAN = 3'd3,
		ST_RUN  = 3'd4,
		ST_EMIT = 3'd5
	} state_t;

	typedef struct packed {
		logic wr;
		logic load_dim;
		logic load_mul;
		logic start_scan;
		dir_t scan_dir;
		logic start_run;
		logic stop;
		logic save_result;
		logic clr_results;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_full;
		logic s1_zero;
		logic s1_end;
	} status_t;

endpackage

// ===== rtl/bbep_pix_if.sv =====
// Pixel request channel of the blob extreme point finder.
// Depends on bbep_pkg for the field widths.
interface bbep_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bbep_pkg::PIX_W-1:0] pixel;
	logic                       end_of_frame;

	modport source (output valid, output pixel, output end_of_frame, input ready);
	modport sink (input valid, input pixel, input end_of_frame, output ready);
endinterface

// ===== rtl/bbep_res_if.sv =====
// Result request channel of the blob extreme point finder.
// Depends on bbep_pkg for the field widths.
interface bbep_res_if;
	logic                     valid;
	logic                     ready;
	logic [bbep_pkg::X_W-1:0] top_x;
	logic [bbep_pkg::Y_W-1:0] top_y;
	logic [bbep_pkg::X_W-1:0] left_x;
	logic [bbep_pkg::Y_W-1:0] left_y;
	logic [bbep_pkg::X_W-1:0] lowest_x;
	logic [bbep_pkg::Y_W-1:0] lowest_y;
	logic [bbep_pkg::X_W-1:0] rightmost_x;
	logic [bbep_pkg::Y_W-1:0] rightmost_y;
	logic [bbep_pkg::X_W-1:0] radius;
	logic                     found;

	modport source (output valid, output top_x, output top_y, output left_x, output left_y,
		output lowest_x, output lowest_y, output rightmost_x, output rightmost_y,
		output radius, output found, input ready);
	modport sink (input valid, input top_x, input top_y, input left_x, input left_y,
		input lowest_x, input lowest_y, input rightmost_x, input rightmost_y,
		input radius, input found, output ready);
endinterface

// ===== rtl/bbep_dp.sv =====
// Datapath of the blob extreme point finder: configuration, frame store,
// scan address walker, run measurement and result registers. Uses bbep_pkg.
module bbep_dp #(
	parameter int MAX_WIDTH  = bbep_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbep_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbep_pkg::cmd_t                 cmd,
	output bbep_pkg::status_t              status,
	input  logic [bbep_pkg::PIX_W-1:0]     pixel,
	input  logic                           end_of_frame,
	input  logic                           cfg_we,
	input  logic [bbep_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbep_pkg::CFG_W-1:0]     cfg_data,
	output logic [bbep_pkg::X_W-1:0]       top_x,
	output logic [bbep_pkg::Y_W-1:0]       top_y,
	output logic [bbep_pkg::X_W-1:0]       left_x,
	output logic [bbep_pkg::Y_W-1:0]       left_y,
	output logic [bbep_pkg::X_W-1:0]       lowest_x,
	output logic [bbep_pkg::Y_W-1:0]       lowest_y,
	output logic [bbep_pkg::X_W-1:0]       rightmost_x,
	output logic [bbep_pkg::Y_W-1:0]       rightmost_y,
	output logic [bbep_pkg::X_W-1:0]       radius,
	output logic                           found
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);

	logic [bbep_pkg::CFG_W-1:0]   cfg_width_q;
	logic [bbep_pkg::CFG_H_W-1:0] cfg_height_q;
	logic [WW-1:0]                w_q;
	logic [HW-1:0]                h_q;
	logic [AW-1:0]                lastrow_q;
	logic [WW-1:0]                w_eff;
	logic [HW-1:0]                h_eff;
	logic [CW-1:0]                wl;
	logic [RW-1:0]                hl;

	logic [1:0]    mem [DEPTH];
	logic [AW-1:0] load_addr_q;
	logic [1:0]    wr_cls;

	bbep_pkg::dir_t dir_q;
	logic           run_q;
	logic           iss_valid_q;
	logic [AW-1:0]  addr_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic           iss_end;
	logic [AW-1:0]  addr_step;
	logic [RW-1:0]  row_step;
	logic [CW-1:0]  col_step;

	logic           valid_s1;
	logic [1:0]     rd_s1;
	logic [AW-1:0]  addr_s1;
	logic [RW-1:0]  row_s1;
	logic [CW-1:0]  col_s1;
	logic           end_s1;

	logic [WW-1:0]  cnt_q;
	logic [RW-1:0]  hit_r_q;
	logic [CW-1:0]  hit_c_q;
	logic [WW:0]    run_n;
	logic [WW-1:0]  half;

	logic [CW-1:0]  tx_q, lx_q, bx_q, rx_q;
	logic [RW-1:0]  ty_q, ly_q, by_q, ry_q;
	logic           found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= bbep_pkg::FRAME_WIDTH_RST;
			cfg_height_q <= bbep_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (bbep_pkg::cfg_idx_t'(cfg_index))
				bbep_pkg::CFG_FRAME_WIDTH:  cfg_width_q  <= cfg_data;
				bbep_pkg::CFG_FRAME_HEIGHT: cfg_height_q <= cfg_data[bbep_pkg::CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_height_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_dim) begin
			w_q <= w_eff;
			h_q <= h_eff;
		end
		if (cmd.load_mul) begin
			lastrow_q <= AW'(AW'(h_q - 1'b1) * AW'(w_q));
		end
	end

	assign wl = CW'(w_q - 1'b1);
	assign hl = RW'(h_q - 1'b1);

	// Each stored pixel is reduced to one of three classes.
	always_comb begin
		if (pixel == bbep_pkg::PIX_FULL) begin
			wr_cls = bbep_pkg::CLS_FULL;
		end else if (pixel == bbep_pkg::PIX_ZERO) begin
			wr_cls = bbep_pkg::CLS_ZERO;
		end else begin
			wr_cls = bbep_pkg::CLS_MID;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[load_addr_q] <= wr_cls;
		end
		rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
		end else if (cmd.wr) begin
			if (end_of_frame || load_addr_q == AW'(DEPTH - 1)) begin
				load_addr_q <= '0;
			end else begin
				load_addr_q <= load_addr_q + 1'b1;
			end
		end
	end

	always_comb begin
		addr_step = addr_q;
		row_step  = row_q;
		col_step  = col_q;
		iss_end   = 1'b0;
		unique case (dir_q)
			bbep_pkg::DIR_TOP: begin
				iss_end   = run_q ? (col_q == wl) : (col_q == wl && row_q == hl);
				addr_step = addr_q + 1'b1;
				if (!run_q && col_q == wl) begin
					col_step = '0;
					row_step = row_q + 1'b1;
				end else begin
					col_step = col_q + 1'b1;
				end
			end
			bbep_pkg::DIR_LEFT: begin
				iss_end = run_q ? (row_q == hl) : (col_q == wl && row_q == hl);
				if (!run_q && row_q == hl) begin
					row_step  = '0;
					col_step  = col_q + 1'b1;
					addr_step = AW'(col_q) + 1'b1;
				end else begin
					row_step  = row_q + 1'b1;
					addr_step = addr_q + AW'(w_q);
				end
			end
			bbep_pkg::DIR_BOTTOM: begin
				iss_end   = run_q ? (col_q == '0) : (col_q == '0 && row_q == '0);
				addr_step = addr_q - 1'b1;
				if (!run_q && col_q == '0) begin
					col_step = wl;
					row_step = row_q - 1'b1;
				end else begin
					col_step = col_q - 1'b1;
				end
			end
			bbep_pkg::DIR_RIGHT: begin
				iss_end = run_q ? (row_q == '0) : (col_q == '0 && row_q == '0);
				if (!run_q && row_q == '0) begin
					row_step  = hl;
					col_step  = col_q - 1'b1;
					addr_step = lastrow_q + AW'(col_q) - 1'b1;
				end else begin
					row_step  = row_q - 1'b1;
					addr_step = addr_q - AW'(w_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_valid_q <= 1'b0;
			run_q       <= 1'b0;
			dir_q       <= bbep_pkg::DIR_TOP;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= iss_valid_q && !(cmd.stop || cmd.start_run || cmd.start_scan);
			if (cmd.stop) begin
				iss_valid_q <= 1'b0;
			end else if (cmd.start_run) begin
				iss_valid_q <= 1'b1;
				run_q       <= 1'b1;
			end else if (cmd.start_scan) begin
				iss_valid_q <= 1'b1;
				run_q       <= 1'b0;
				dir_q       <= cmd.scan_dir;
			end else if (iss_valid_q && iss_end) begin
				iss_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		row_s1  <= row_q;
		col_s1  <= col_q;
		end_s1  <= iss_end;
		if (cmd.start_run) begin
			addr_q  <= addr_s1;
			row_q   <= row_s1;
			col_q   <= col_s1;
			hit_r_q <= row_s1;
			hit_c_q <= col_s1;
			cnt_q   <= '0;
		end else if (cmd.start_scan) begin
			if (cmd.scan_dir == bbep_pkg::DIR_TOP || cmd.scan_dir == bbep_pkg::DIR_LEFT) begin
				addr_q <= '0;
				row_q  <= '0;
				col_q  <= '0;
			end else begin
				addr_q <= lastrow_q + AW'(wl);
				row_q  <= hl;
				col_q  <= wl;
			end
		end else begin
			if (iss_valid_q && !iss_end) begin
				addr_q <= addr_step;
				row_q  <= row_step;
				col_q  <= col_step;
			end
			if (valid_s1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign status.s1_valid = valid_s1;
	assign status.s1_full  = rd_s1 == bbep_pkg::CLS_FULL;
	assign status.s1_zero  = rd_s1 == bbep_pkg::CLS_ZERO;
	assign status.s1_end   = end_s1;

	// A run that ends on a zero pixel counts it; the hit moves by half the run.
	assign run_n = {1'b0, cnt_q} + 1'b1;
	assign half  = status.s1_zero ? run_n[WW:1] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.clr_results) begin
			found_q <= 1'b0;
		end else if (cmd.save_result) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_results) begin
			tx_q <= '0;
			ty_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else if (cmd.save_result) begin
			unique case (dir_q)
				bbep_pkg::DIR_TOP: begin
					tx_q <= CW'(32'(hit_c_q) + 32'(half));
					ty_q <= hit_r_q;
				end
				bbep_pkg::DIR_LEFT: begin
					lx_q <= hit_c_q;
					ly_q <= RW'(32'(hit_r_q) + 32'(half));
				end
				bbep_pkg::DIR_BOTTOM: begin
					bx_q <= CW'(32'(hit_c_q) - 32'(half));
					by_q <= hit_r_q;
				end
				bbep_pkg::DIR_RIGHT: begin
					rx_q <= hit_c_q;
					ry_q <= RW'(32'(hit_r_q) - 32'(half));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			top_x       <= bbep_pkg::X_W'(tx_q);
			top_y       <= bbep_pkg::Y_W'(ty_q);
			left_x      <= bbep_pkg::X_W'(lx_q);
			left_y      <= bbep_pkg::Y_W'(ly_q);
			lowest_x    <= bbep_pkg::X_W'(bx_q);
			lowest_y    <= bbep_pkg::Y_W'(by_q);
			rightmost_x <= bbep_pkg::X_W'(rx_q);
			rightmost_y <= bbep_pkg::Y_W'(ry_q);
			radius      <= bbep_pkg::X_W'((bx_q >= rx_q) ? (bx_q - rx_q) : (rx_q - bx_q));
			found       <= found_q;
		end
	end

endmodule

// ===== rtl/bbep_ctrl.sv =====
// Controller of the blob extreme point finder: frame loading, up to four
// scans with their run measurements, and the result handshake. Uses bbep_pkg.
module bbep_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bbep_pkg::cmd_t      cmd,
	input  bbep_pkg::status_t   status
);

	bbep_pkg::state_t state_q, state_d;
	bbep_pkg::dir_t   dir_q, dir_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbep_pkg::ST_LOAD;
			dir_q   <= bbep_pkg::DIR_TOP;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		dir_d    = dir_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.scan_dir = bbep_pkg::DIR_TOP;
		unique case (state_q)
			bbep_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr = 1'b1;
					if (in_end) begin
						state_d = bbep_pkg::ST_DIM;
					end
				end
			end
			bbep_pkg::ST_DIM: begin
				cmd.load_dim = 1'b1;
				state_d      = bbep_pkg::ST_MUL;
			end
			bbep_pkg::ST_MUL: begin
				cmd.load_mul   = 1'b1;
				cmd.start_scan = 1'b1;
				dir_d          = bbep_pkg::DIR_TOP;
				state_d        = bbep_pkg::ST_SCAN;
			end
			bbep_pkg::ST_SCAN: begin
				if (status.s1_valid && status.s1_full) begin
					cmd.start_run = 1'b1;
					state_d       = bbep_pkg::ST_RUN;
				end else if (status.s1_valid && status.s1_end) begin
					cmd.stop        = 1'b1;
					cmd.clr_results = 1'b1;
					state_d         = bbep_pkg::ST_EMIT;
				end
			end
			bbep_pkg::ST_RUN: begin
				if (status.s1_valid && (status.s1_zero || status.s1_end)) begin
					cmd.save_result = 1'b1;
					unique case (dir_q)
						bbep_pkg::DIR_TOP:    dir_d = bbep_pkg::DIR_LEFT;
						bbep_pkg::DIR_LEFT:   dir_d = bbep_pkg::DIR_BOTTOM;
						bbep_pkg::DIR_BOTTOM: dir_d = bbep_pkg::DIR_RIGHT;
						default:              dir_d = bbep_pkg::DIR_TOP;
					endcase
					if (dir_q == bbep_pkg::DIR_RIGHT) begin
						cmd.stop = 1'b1;
						state_d  = bbep_pkg::ST_EMIT;
					end else begin
						cmd.start_scan = 1'b1;
						cmd.scan_dir   = dir_d;
						state_d        = bbep_pkg::ST_SCAN;
					end
				end
			end
			bbep_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = bbep_pkg::ST_LOAD;
				end
			end
			default: state_d = bbep_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result is still waiting");

	a_hit_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbep_pkg::ST_SCAN && status.s1_valid && status.s1_full)
		|=> state_q == bbep_pkg::ST_RUN)
		else $error("foreground hit did not start a run measurement");

	a_miss_only_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbep_pkg::ST_SCAN && status.s1_valid && status.s1_end && !status.s1_full)
		|-> dir_q == bbep_pkg::DIR_TOP)
		else $error("a later scan ran off the frame without a hit");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (state_q == bbep_pkg::ST_LOAD && !status.s1_valid))
		else $error("frame store written while a scan is running");

endmodule

// ===== rtl/binary_blob_extreme_point_finder.sv =====
// Pixels load at one per cycle while the block waits in its load state; after the last pixel
// the scans and their runs, up to four, read the frame store one entry at a time, then the result
// is loaded; the next frame is not taken until the result register has taken the result.
// Scan speed is set by the single read port of the frame store.
// Reset clears control, sets 640 x 480; the store is not cleared.
module binary_blob_extreme_point_finder #(
	parameter int MAX_WIDTH  = bbep_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbep_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bbep_pix_if.sink                       pixels,
	bbep_res_if.source                     results,
	input  logic                           cfg_we,
	input  logic [bbep_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbep_pkg::CFG_W-1:0]     cfg_data
);

	bbep_pkg::cmd_t    cmd;
	bbep_pkg::status_t status;

	bbep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixels.valid),
		.in_end    (pixels.end_of_frame),
		.in_ready  (pixels.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status)
	);

	bbep_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.pixel        (pixels.pixel),
		.end_of_frame (pixels.end_of_frame),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.top_x        (results.top_x),
		.top_y        (results.top_y),
		.left_x       (results.left_x),
		.left_y       (results.left_y),
		.lowest_x     (results.lowest_x),
		.lowest_y     (results.lowest_y),
		.rightmost_x  (results.rightmost_x),
		.rightmost_y  (results.rightmost_y),
		.radius       (results.radius),
		.found        (results.found)
	);

endmodule

// ===== test/binary_blob_extreme_point_finder_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the binary blob extreme point finder: streams directed and random frames,
// predicts the four extreme points of every frame and checks each result request.
// Depends on bbep_pkg, the bbep_pix_if and bbep_res_if interfaces and the block itself.
module binary_blob_extreme_point_finder_tb;

	localparam int STORE_DEPTH = bbep_pkg::MAX_WIDTH_DEF * bbep_pkg::MAX_HEIGHT_DEF;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int unsigned SEND_IDLE [4] = '{0, 59, 0, 27};
	localparam int unsigned RECV_STALL [4] = '{0, 0, 59, 27};

	typedef enum {SHAPE_EMPTY, SHAPE_SOLID, SHAPE_NOISE, SHAPE_RECT} frame_shape_t;

	typedef struct packed {
		logic [bbep_pkg::PIX_W-1:0] pixel;
		logic                       end_of_frame;
	} pixel_req_t;

	typedef struct packed {
		logic [bbep_pkg::X_W-1:0] top_x;
		logic [bbep_pkg::Y_W-1:0] top_y;
		logic [bbep_pkg::X_W-1:0] left_x;
		logic [bbep_pkg::Y_W-1:0] left_y;
		logic [bbep_pkg::X_W-1:0] lowest_x;
		logic [bbep_pkg::Y_W-1:0] lowest_y;
		logic [bbep_pkg::X_W-1:0] rightmost_x;
		logic [bbep_pkg::Y_W-1:0] rightmost_y;
		logic [bbep_pkg::X_W-1:0] radius;
		logic                     found;
	} extremes_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       pix_valid = 1'b0;
	logic [bbep_pkg::PIX_W-1:0] pix_value = '0;
	logic                       pix_last = 1'b0;
	logic                       res_ready = 1'b0;
	logic                       cfg_we = 1'b0;
	bbep_pkg::cfg_idx_t         cfg_index = bbep_pkg::CFG_FRAME_WIDTH;
	logic [bbep_pkg::CFG_W-1:0] cfg_data = '0;

	bbep_pkg::cls_t               frame_mem [STORE_DEPTH];
	int unsigned                  store_addr = 0;
	int unsigned                  written_span = 0;
	logic [bbep_pkg::CFG_W-1:0]   width_reg = bbep_pkg::FRAME_WIDTH_RST;
	logic [bbep_pkg::CFG_H_W-1:0] height_reg = bbep_pkg::FRAME_HEIGHT_RST;
	pixel_req_t                   pending_pixels [$];
	extremes_t                    expected_extremes [$];
	int unsigned                  send_idle_pct = 0;
	int unsigned                  recv_stall_pct = 0;
	int unsigned                  holdoff_left = 0;
	int unsigned                  holdoff_requests = 0;
	int unsigned                  holdoff_served = 0;
	int unsigned                  error_count = 0;
	int unsigned                  pixels_sent = 0;
	int unsigned                  frames_checked = 0;
	int unsigned                  empty_frames = 0;
	int unsigned                  settings_used = 0;

	bbep_pix_if pix_ch ();
	bbep_res_if res_ch ();

	assign pix_ch.valid = pix_valid;
	assign pix_ch.pixel = pix_value;
	assign pix_ch.end_of_frame = pix_last;
	assign res_ch.ready = res_ready;

	binary_blob_extreme_point_finder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_ch),
		.results  (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > bbep_pkg::MAX_WIDTH_DEF) return bbep_pkg::MAX_WIDTH_DEF;
		return int'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > bbep_pkg::MAX_HEIGHT_DEF) return bbep_pkg::MAX_HEIGHT_DEF;
		return int'(height_reg);
	endfunction

	function automatic extremes_t find_extremes();
		int unsigned w, h, r, c, n;
		int unsigned tx, ty, lx, ly, bx, by, rx, ry;
		bit hit;
		extremes_t res;
		w = eff_width();
		h = eff_height();
		tx = 0; ty = 0; lx = 0; ly = 0; bx = 0; by = 0; rx = 0; ry = 0;
		hit = 1'b0;
		res = '0;
		for (r = 0; r < h && !hit; r++)
			for (c = 0; c < w && !hit; c++)
				if (frame_mem[r * w + c] == bbep_pkg::CLS_FULL) begin
					tx = c; ty = r; hit = 1'b1;
				end
		if (!hit) return res;

		// A hit whose run ends on a zero pixel slides half the run length, that zero pixel included.
		n = 0;
		for (c = tx; c < w; c++) begin
			n++;
			if (frame_mem[ty * w + c] == bbep_pkg::CLS_ZERO) begin
				tx += n / 2;
				break;
			end
		end

		hit = 1'b0;
		for (c = 0; c < w && !hit; c++)
			for (r = 0; r < h && !hit; r++)
				if (frame_mem[r * w + c] == bbep_pkg::CLS_FULL) begin
					lx = c; ly = r; hit = 1'b1;
				end
		n = 0;
		for (r = ly; r < h; r++) begin
			n++;
			if (frame_mem[r * w + lx] == bbep_pkg::CLS_ZERO) begin
				ly += n / 2;
				break;
			end
		end

		hit = 1'b0;
		for (r = h; r > 0 && !hit; r--)
			for (c = w; c > 0 && !hit; c--)
				if (frame_mem[(r - 1) * w + c - 1] == bbep_pkg::CLS_FULL) begin
					bx = c - 1; by = r - 1; hit = 1'b1;
				end
		n = 0;
		for (c = bx + 1; c > 0; c--) begin
			n++;
			if (frame_mem[by * w + c - 1] == bbep_pkg::CLS_ZERO) begin
				bx -= n / 2;
				break;
			end
		end

		hit = 1'b0;
		for (c = w; c > 0 && !hit; c--)
			for (r = h; r > 0 && !hit; r--)
				if (frame_mem[(r - 1) * w + c - 1] == bbep_pkg::CLS_FULL) begin
					rx = c - 1; ry = r - 1; hit = 1'b1;
				end
		n = 0;
		for (r = ry + 1; r > 0; r--) begin
			n++;
			if (frame_mem[(r - 1) * w + rx] == bbep_pkg::CLS_ZERO) begin
				ry -= n / 2;
				break;
			end
		end

		res.top_x = bbep_pkg::X_W'(tx);
		res.top_y = bbep_pkg::Y_W'(ty);
		res.left_x = bbep_pkg::X_W'(lx);
		res.left_y = bbep_pkg::Y_W'(ly);
		res.lowest_x = bbep_pkg::X_W'(bx);
		res.lowest_y = bbep_pkg::Y_W'(by);
		res.rightmost_x = bbep_pkg::X_W'(rx);
		res.rightmost_y = bbep_pkg::Y_W'(ry);
		res.radius = bbep_pkg::X_W'(bx >= rx ? bx - rx : rx - bx);
		res.found = 1'b1;
		return res;
	endfunction

	task automatic report_failure(input string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_failure($sformatf("result %0d: %s is %0d, expected %0d",
				frames_checked, name, got, want));
	endtask

	// Pixel driver; the store mirror is updated on every accepted request.
	always @(posedge clk) begin
		pixel_req_t next_req;
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ch.ready) begin
				if (pix_value == bbep_pkg::PIX_FULL) frame_mem[store_addr] = bbep_pkg::CLS_FULL;
				else if (pix_value == bbep_pkg::PIX_ZERO) frame_mem[store_addr] = bbep_pkg::CLS_ZERO;
				else frame_mem[store_addr] = bbep_pkg::CLS_MID;
				store_addr = (store_addr + 1 == STORE_DEPTH) ? 0 : store_addr + 1;
				pixels_sent++;
				if (pix_last) begin
					store_addr = 0;
					expected_extremes.push_back(find_extremes());
				end
			end
			if (!pix_valid || pix_ch.ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_pixels.pop_front();
					pix_valid <= 1'b1;
					pix_value <= next_req.pixel;
					pix_last <= next_req.end_of_frame;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_served != holdoff_requests) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_served <= holdoff_served + 1;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		extremes_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ready) begin
				if (expected_extremes.size() == 0) begin
					report_failure("result request with no frame pending");
				end else begin
					want = expected_extremes.pop_front();
					check_field("top_x", 16'(res_ch.top_x), 16'(want.top_x));
					check_field("top_y", 16'(res_ch.top_y), 16'(want.top_y));
					check_field("left_x", 16'(res_ch.left_x), 16'(want.left_x));
					check_field("left_y", 16'(res_ch.left_y), 16'(want.left_y));
					check_field("lowest_x", 16'(res_ch.lowest_x), 16'(want.lowest_x));
					check_field("lowest_y", 16'(res_ch.lowest_y), 16'(want.lowest_y));
					check_field("rightmost_x", 16'(res_ch.rightmost_x),
						16'(want.rightmost_x));
					check_field("rightmost_y", 16'(res_ch.rightmost_y),
						16'(want.rightmost_y));
					check_field("radius", 16'(res_ch.radius), 16'(want.radius));
					check_field("found", 16'(res_ch.found), 16'(want.found));
					if (!want.found) empty_frames++;
					frames_checked++;
				end
			end
			res_ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic write_register(input bbep_pkg::cfg_idx_t idx,
			input logic [bbep_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == bbep_pkg::CFG_FRAME_WIDTH) width_reg = value;
		else height_reg = value[bbep_pkg::CFG_H_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || pix_valid || expected_extremes.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_pixel(input logic [bbep_pkg::PIX_W-1:0] value, input logic last);
		pixel_req_t req;
		req.pixel = value;
		req.end_of_frame = last;
		pending_pixels.push_back(req);
	endtask

	// The first pixel sits in the most significant used byte.
	task automatic queue_bytes(input int unsigned count, input logic [63:0] bytes);
		for (int unsigned i = 0; i < count; i++)
			queue_pixel(bytes[8 * (count - 1 - i) +: 8], i == count - 1);
		if (count > written_span) written_span = count;
	endtask

	task automatic queue_random_frame(output int unsigned len);
		int unsigned w, h, total, r0, r1, c0, c1, row, col, roll;
		logic [bbep_pkg::PIX_W-1:0] value;
		frame_shape_t shape;
		w = eff_width();
		h = eff_height();
		total = w * h;
		roll = $urandom_range(0, 99);
		// A short frame is only sent where the entries it leaves alone hold earlier pixels.
		if (roll < 10 && total > 1 && written_span >= total) len = $urandom_range(1, total - 1);
		else if (roll < 15) len = total + $urandom_range(1, 4);
		else len = total;
		roll = $urandom_range(0, 9);
		shape = (roll == 0) ? SHAPE_EMPTY : (roll == 1) ? SHAPE_SOLID :
			(roll < 5) ? SHAPE_NOISE : SHAPE_RECT;
		r0 = $urandom_range(0, h - 1);
		r1 = $urandom_range(r0, h - 1);
		c0 = $urandom_range(0, w - 1);
		c1 = $urandom_range(c0, w - 1);
		for (int unsigned i = 0; i < len; i++) begin
			row = (i / w) % h;
			col = i % w;
			roll = $urandom_range(0, 99);
			case (shape)
			SHAPE_EMPTY: value = bbep_pkg::PIX_W'($urandom_range(0, 254));
			SHAPE_SOLID: value = bbep_pkg::PIX_FULL;
			SHAPE_NOISE: begin
				value = roll < 40 ? bbep_pkg::PIX_ZERO : roll < 75 ? bbep_pkg::PIX_FULL :
					bbep_pkg::PIX_W'($urandom_range(1, 254));
			end
			SHAPE_RECT: begin
				if (row >= r0 && row <= r1 && col >= c0 && col <= c1)
					value = roll < 5 ? bbep_pkg::PIX_ZERO :
						roll < 15 ? bbep_pkg::PIX_W'($urandom_range(1, 254)) :
						bbep_pkg::PIX_FULL;
				else
					value = roll < 10 ? bbep_pkg::PIX_W'($urandom_range(0, 254)) :
						bbep_pkg::PIX_ZERO;
			end
			default: value = bbep_pkg::PIX_ZERO;
			endcase
			queue_pixel(value, i == len - 1);
		end
		if (len > written_span) written_span = len;
	endtask

	task automatic run_setting(input logic [bbep_pkg::CFG_W-1:0] w_value,
			input logic [bbep_pkg::CFG_W-1:0] h_value,
			input int unsigned min_frames, input int unsigned min_pixels);
		int unsigned frames, pixels, len;
		write_register(bbep_pkg::CFG_FRAME_WIDTH, w_value);
		write_register(bbep_pkg::CFG_FRAME_HEIGHT, h_value);
		settings_used++;
		frames = 0;
		pixels = 0;
		while (frames < min_frames || pixels < min_pixels) begin
			queue_random_frame(len);
			pixels += len;
			frames++;
		end
		wait_drained();
	endtask

	initial begin
		logic [bbep_pkg::CFG_W-1:0] w_value, h_value;
		int unsigned frame_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames: a blob and an all-white frame, both with runs that reach the frame edge,
		// a frame with no white pixel at all, single-pixel frames and a short frame.
		write_register(bbep_pkg::CFG_FRAME_WIDTH, 11'd3);
		write_register(bbep_pkg::CFG_FRAME_HEIGHT, 11'd2);
		queue_bytes(6, 64'({8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0}));
		queue_bytes(6, 64'({8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd64}));
		queue_bytes(6, 64'({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}));
		wait_drained();
		write_register(bbep_pkg::CFG_FRAME_WIDTH, 11'd1);
		write_register(bbep_pkg::CFG_FRAME_HEIGHT, 11'd1);
		queue_bytes(1, 64'({8'd255}));
		queue_bytes(1, 64'({8'd0}));
		wait_drained();
		write_register(bbep_pkg::CFG_FRAME_WIDTH, 11'd2);
		write_register(bbep_pkg::CFG_FRAME_HEIGHT, 11'd2);
		queue_bytes(2, 64'({8'd0, 8'd255}));
		wait_drained();
		settings_used += 3;

		// Zero registers clamp to a single pixel.
		run_setting(11'd0, 11'd0, 2, 0);

		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = SEND_IDLE[mode];
			recv_stall_pct = RECV_STALL[mode];
			if (mode == 0) begin
				write_register(bbep_pkg::CFG_FRAME_WIDTH, 11'd3);
				write_register(bbep_pkg::CFG_FRAME_HEIGHT, 11'd3);
				holdoff_requests++;
				for (int k = 0; k < 6; k++) queue_random_frame(frame_len);
				wait_drained();
			end
			for (int k = 0; k < 3; k++) begin
				w_value = ($urandom_range(0, 19) == 0) ? 11'd0 :
					bbep_pkg::CFG_W'($urandom_range(1, 8));
				h_value = ($urandom_range(0, 19) == 0) ? 11'd0 :
					bbep_pkg::CFG_W'($urandom_range(1, 6));
				h_value[bbep_pkg::CFG_W-1] = 1'($urandom_range(0, 1));
				run_setting(w_value, h_value, 4, 32);
			end
		end

		$display("Checked %0d frame results (%0d without a white pixel) from %0d pixel requests.",
			frames_checked, empty_frames, pixels_sent);
		$display("Used %0d frame geometries incl. zero registers, four idle mixes and a hold-off.",
			settings_used);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
